// File: design/ggnc_pkg.sv
// ggnc_pkg: widths, state encoding and shared types for the global norm clipping core
// no dependencies; imported by every module of the core
`default_nettype none

package ggnc_pkg;

    // fixed-point format of gradient elements and of the scale factor
    localparam int FRAC_BITS = 24;
    localparam int DATA_BITS = 32;

    // port widths
    localparam int GRAD_W = 32;
    localparam int NORM_W = 32;

    // multiplier operand and product widths
    localparam int MUL_B_W = (DATA_BITS > FRAC_BITS) ? DATA_BITS : FRAC_BITS;
    localparam int PROD_W  = DATA_BITS + MUL_B_W;

    // square sum, square root and shared subtractor widths
    localparam int SUM_W      = 64;
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int SUB_W      = NORM_W + 4;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // result word kinds
    localparam logic KIND_NORM  = 1'b0;
    localparam logic KIND_SCALE = 1'b1;

    // input word actions
    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_SCALE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SQRT,
        S_CMP,
        S_DIV,
        S_OUT
    } state_t;

    // result of the shared subtract and compare unit
    typedef struct packed {
        logic             ge;
        logic [SUB_W-1:0] diff;
    } sub_res_t;

endpackage

`default_nettype wire

// File: design/gradient_global_norm_clip_core.sv
// gradient_global_norm_clip_core: top level of the global L2 norm gradient clipping core
// depends on ggnc_pkg, ggnc_mul and ggnc_sub
`default_nettype none

// Two-pass gradient clipping in Q8.24. Pass one words (action 0) add the element's square
// to a saturating Q16.48 sum; the word marked end_of_pass yields one norm report (kind 0)
// carrying the floored square root and the clipped flag. Pass two words (action 1) each
// yield the element scaled by limit/norm, or unchanged when not clipped; the last one
// clears the state. One word is in flight at a time and in_stall is high while it is
// worked on. An accumulate word without end mark passes the shared multiplier and the
// accumulate step; a scale word passes these and the output handoff. An end-of-pass
// word then runs the square root in 32 steps, the limit check and, when clipped, the
// division in 24 steps on one shared subtract and compare unit. A result waits
// in the output register while the next word is accepted. norm_limit is taken at any time
// through cfg_valid with cfg_ready held high, and must only change while the core is idle.
module gradient_global_norm_clip_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ggnc_pkg::NORM_W-1:0]         cfg_data,
    // input channel
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                action,
    input  wire logic signed [ggnc_pkg::GRAD_W-1:0]  grad_value,
    input  wire logic                                end_of_pass,
    // output channel
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     kind,
    output logic signed [ggnc_pkg::GRAD_W-1:0]       scaled_value,
    output logic        [ggnc_pkg::NORM_W-1:0]       norm_value,
    output logic                                     clipped,
    output logic                                     final_element
);
    import ggnc_pkg::*;

    // control state
    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]     square_sum_reg, square_sum_next;
    logic [FRAC_BITS-1:0] scale_factor_reg, scale_factor_next;
    logic                 clip_active_reg, clip_active_next;
    logic [NORM_W-1:0]    norm_limit_reg;

    // captured input word
    logic                 action_reg, action_next;
    logic                 last_reg, last_next;
    logic                 neg_reg, neg_next;
    logic [DATA_BITS-1:0] mag_reg, mag_next;

    // iteration registers
    logic [SUB_W-1:0]     rem_reg, rem_next;
    logic [NORM_W-1:0]    root_reg, root_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    // pending result word
    logic                 pend_kind_reg, pend_kind_next;
    logic [GRAD_W-1:0]    pend_scaled_reg, pend_scaled_next;
    logic [NORM_W-1:0]    pend_norm_reg, pend_norm_next;
    logic                 pend_clipped_reg, pend_clipped_next;
    logic                 pend_final_reg, pend_final_next;

    // output word
    logic                 kind_reg, kind_next;
    logic [GRAD_W-1:0]    scaled_reg, scaled_next;
    logic [NORM_W-1:0]    norm_reg, norm_next;
    logic                 clipped_reg, clipped_next;
    logic                 final_reg, final_next;

    // shared units
    logic                 mul_en;
    logic [MUL_B_W-1:0]   mul_b;
    logic [PROD_W-1:0]    product;
    logic [SUB_W-1:0]     sub_a, sub_b;
    sub_res_t             sub_res;

    // datapath helpers
    logic [DATA_BITS-1:0] raw;
    logic                 raw_neg;
    logic [DATA_BITS-1:0] raw_mag;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sat_sum;
    logic [DATA_BITS-1:0] res_mag;
    logic [GRAD_W-1:0]    res_ext;
    logic [GRAD_W-1:0]    res_word;
    logic                 out_free;

    // sign and magnitude of the incoming element
    assign raw     = grad_value[DATA_BITS-1:0];
    assign raw_neg = raw[DATA_BITS-1];
    assign raw_mag = raw_neg ? ({DATA_BITS{1'b0}} - raw) : raw;

    // multiplier squares the magnitude or scales it by the factor
    assign mul_b = (action_reg == ACT_SCALE) ? MUL_B_W'(scale_factor_reg) : MUL_B_W'(mag_reg);

    ggnc_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mag_reg),
        .b       (mul_b),
        .product (product)
    );

    ggnc_sub u_sub (
        .a   (sub_a),
        .b   (sub_b),
        .res (sub_res)
    );

    // saturating accumulation of the square
    always_comb
    begin
        sum_wide = {1'b0, square_sum_reg} + {1'b0, SUM_W'(product[2*DATA_BITS-1:0])};
        sat_sum  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
    end

    // scaled element, truncated toward zero by working on the magnitude
    always_comb
    begin
        res_mag  = clip_active_reg ? product[FRAC_BITS +: DATA_BITS] : mag_reg;
        res_ext  = GRAD_W'(res_mag);
        res_word = neg_reg ? ({GRAD_W{1'b0}} - res_ext) : res_ext;
    end

    assign out_free = ~out_valid_reg | ~out_stall;

    // sequencer: next state, datapath selects and register updates
    always_comb
    begin
        state_next        = state_reg;
        square_sum_next   = square_sum_reg;
        scale_factor_next = scale_factor_reg;
        clip_active_next  = clip_active_reg;
        action_next       = action_reg;
        last_next         = last_reg;
        neg_next          = neg_reg;
        mag_next          = mag_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        cnt_next          = cnt_reg;
        pend_kind_next    = pend_kind_reg;
        pend_scaled_next  = pend_scaled_reg;
        pend_norm_next    = pend_norm_reg;
        pend_clipped_next = pend_clipped_reg;
        pend_final_next   = pend_final_reg;
        kind_next         = kind_reg;
        scaled_next       = scaled_reg;
        norm_next         = norm_reg;
        clipped_next      = clipped_reg;
        final_next        = final_reg;
        out_valid_next    = out_valid_reg & out_stall;
        mul_en            = 1'b0;
        sub_a             = '0;
        sub_b             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    action_next = action;
                    last_next   = end_of_pass;
                    neg_next    = raw_neg;
                    mag_next    = raw_mag;
                    state_next  = S_MUL;
                end
            end

            S_MUL:
            begin
                mul_en     = 1'b1;
                state_next = S_ACC;
            end

            S_ACC:
            begin
                if (action_reg == ACT_ACCUM)
                begin
                    square_sum_next = sat_sum;
                    if (last_reg)
                    begin
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = CNT_W'(SQRT_STEPS - 1);
                        state_next = S_SQRT;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    pend_kind_next    = KIND_SCALE;
                    pend_scaled_next  = res_word;
                    pend_norm_next    = '0;
                    pend_clipped_next = clip_active_reg;
                    pend_final_next   = last_reg;
                    if (last_reg)
                    begin
                        square_sum_next   = '0;
                        scale_factor_next = '0;
                        clip_active_next  = 1'b0;
                    end
                    state_next = S_OUT;
                end
            end

            // one root bit a step, the sum shifts out two bits at a time and ends at zero
            S_SQRT:
            begin
                sub_a           = {rem_reg[SUB_W-3:0], square_sum_reg[SUM_W-1 -: 2]};
                sub_b           = SUB_W'({root_reg, 2'b01});
                rem_next        = sub_res.ge ? sub_res.diff : sub_a;
                root_next       = {root_reg[NORM_W-2:0], sub_res.ge};
                square_sum_next = square_sum_reg << 2;
                if (cnt_reg == '0)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // clipping only when a limit is set and the norm is strictly above it
            S_CMP:
            begin
                sub_a = SUB_W'(norm_limit_reg);
                sub_b = SUB_W'(root_reg);
                if ((norm_limit_reg != '0) && !sub_res.ge)
                begin
                    rem_next   = SUB_W'(norm_limit_reg);
                    cnt_next   = CNT_W'(FRAC_BITS - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    scale_factor_next = '0;
                    clip_active_next  = 1'b0;
                    pend_kind_next    = KIND_NORM;
                    pend_scaled_next  = '0;
                    pend_norm_next    = root_reg;
                    pend_clipped_next = 1'b0;
                    pend_final_next   = 1'b0;
                    state_next        = S_OUT;
                end
            end

            // restoring division of the limit by the norm, one quotient bit a step
            S_DIV:
            begin
                sub_a             = {rem_reg[SUB_W-2:0], 1'b0};
                sub_b             = SUB_W'(root_reg);
                rem_next          = sub_res.ge ? sub_res.diff : sub_a;
                scale_factor_next = {scale_factor_reg[FRAC_BITS-2:0], sub_res.ge};
                if (cnt_reg == '0)
                begin
                    clip_active_next  = 1'b1;
                    pend_kind_next    = KIND_NORM;
                    pend_scaled_next  = '0;
                    pend_norm_next    = root_reg;
                    pend_clipped_next = 1'b1;
                    pend_final_next   = 1'b0;
                    state_next        = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end

            // hand the pending word to the output register once it is free
            S_OUT:
            begin
                if (out_free)
                begin
                    kind_next      = pend_kind_reg;
                    scaled_next    = pend_scaled_reg;
                    norm_next      = pend_norm_reg;
                    clipped_next   = pend_clipped_reg;
                    final_next     = pend_final_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            square_sum_reg   <= '0;
            scale_factor_reg <= '0;
            clip_active_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            square_sum_reg   <= square_sum_next;
            scale_factor_reg <= scale_factor_next;
            clip_active_reg  <= clip_active_next;
        end
    end

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_limit_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            norm_limit_reg <= cfg_data;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        action_reg       <= action_next;
        last_reg         <= last_next;
        neg_reg          <= neg_next;
        mag_reg          <= mag_next;
        rem_reg          <= rem_next;
        root_reg         <= root_next;
        cnt_reg          <= cnt_next;
        pend_kind_reg    <= pend_kind_next;
        pend_scaled_reg  <= pend_scaled_next;
        pend_norm_reg    <= pend_norm_next;
        pend_clipped_reg <= pend_clipped_next;
        pend_final_reg   <= pend_final_next;
        kind_reg         <= kind_next;
        scaled_reg       <= scaled_next;
        norm_reg         <= norm_next;
        clipped_reg      <= clipped_next;
        final_reg        <= final_next;
    end

    // ports
    assign cfg_ready     = 1'b1;
    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign scaled_value  = $signed(scaled_reg);
    assign norm_value    = norm_reg;
    assign clipped       = clipped_reg;
    assign final_element = final_reg;

endmodule

`default_nettype wire

// File: design/ggnc_sub.sv
// ggnc_sub: shared subtract and compare unit for square root, limit check and division
// depends on ggnc_pkg
`default_nettype none

module ggnc_sub (
    input  wire logic [ggnc_pkg::SUB_W-1:0] a,
    input  wire logic [ggnc_pkg::SUB_W-1:0] b,
    output ggnc_pkg::sub_res_t              res
);
    import ggnc_pkg::*;

    logic [SUB_W:0] wide;

    // borrow out of the subtraction tells whether a is below b
    always_comb
    begin
        wide     = {1'b0, a} - {1'b0, b};
        res.ge   = ~wide[SUB_W];
        res.diff = wide[SUB_W-1:0];
    end

endmodule

`default_nettype wire

// File: design/ggnc_mul.sv
// ggnc_mul: shared multiplier with registered product, used for squares and for scaling
// depends on ggnc_pkg
`default_nettype none

module ggnc_mul (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [ggnc_pkg::DATA_BITS-1:0] a,
    input  wire logic [ggnc_pkg::MUL_B_W-1:0]   b,
    output logic      [ggnc_pkg::PROD_W-1:0]    product
);
    import ggnc_pkg::*;

    logic [PROD_W-1:0] product_reg;

    // product register, no reset needed for payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= PROD_W'(a) * PROD_W'(b);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire
